// File: src/speq_pkg.sv
// ----------------------------------------------------------------------------
// speq_pkg: shared types and codes of the sorted edge priority queue
// Edge record, command codes, result status codes and stream field widths.
// ----------------------------------------------------------------------------
package speq_pkg;

	localparam int unsigned VertexW = 10;
	localparam int unsigned WeightW = 16;
	localparam int unsigned CountW  = 7;
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 48;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_DROPPED  = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [WeightW-1:0] weight;
		logic [VertexW-1:0]        second_vertex;
		logic [VertexW-1:0]        first_vertex;
	} edge_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic  ins_en;
		logic  rem_en;
		edge_t new_edge;
	} cell_ctrl_t;

endpackage

// File: src/speq_cell.sv
// ----------------------------------------------------------------------------
// speq_cell: one slot of the sorted chain
// Holds one edge; on insert it keeps, takes the new edge or takes its left
// neighbor's edge; on remove it takes its right neighbor's edge.
// ----------------------------------------------------------------------------
module speq_cell (
	input  logic                clk,
	input  logic                slot_valid,
	input  speq_pkg::cell_ctrl_t ctrl,
	input  logic                left_less,
	input  speq_pkg::edge_t     left_edge,
	input  speq_pkg::edge_t     right_edge,
	output logic                less,
	output speq_pkg::edge_t     edge_q
);

	// this slot stays ahead of the new edge only when strictly lighter
	assign less = slot_valid && (edge_q.weight < ctrl.new_edge.weight);

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (!less) begin
				edge_q <= left_less ? ctrl.new_edge : left_edge;
			end
		end else if (ctrl.rem_en) begin
			edge_q <= right_edge;
		end
	end

endmodule

// File: src/sorted_edge_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_edge_priority_queue: minimum-first sorted queue of graph edges
// A chain of CAPACITY cells keeps edges in ascending weight order.
// ----------------------------------------------------------------------------
// Usage:
// Input beats on s_axis carry a command in tuser (insert or remove) and an
// edge in tdata. Insert places the edge ahead of the first stored edge of
// equal or greater weight; remove returns the lightest edge. Every input
// beat gives exactly one result beat on m_axis with a status in tuser and
// the removed edge, entry count and empty flag in tdata.
// The result beat follows in the cycle after its input beat. Throughput is one
// beat per cycle: every cell compares its weight with the new key and
// shifts left or right in the same cycle, so the chain needs no ripple.
// The result sits in an output register; a new beat is taken whenever that
// register is empty or is being drained in the same cycle, so a stall at
// m_axis holds s_axis_tready low until the result is taken.
// Reset empties the queue (count to zero) and drops any pending result;
// slot contents are not cleared and are never read before being written.
// A full insert is dropped with status 3; a remove on empty gives status 2.
// ----------------------------------------------------------------------------
module sorted_edge_priority_queue #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [9:0] first_vertex, [19:10] second_vertex, [35:20] edge_weight, [39:36] zero
	input  logic [speq_pkg::InDataW-1:0] s_axis_tdata,
	// [0] cmd
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [9:0] out_first_vertex, [19:10] out_second_vertex, [35:20] out_weight,
	// [42:36] entry_count, [43] is_empty, [47:44] zero
	output logic [speq_pkg::OutDataW-1:0] m_axis_tdata,
	// [1:0] status
	output logic [1:0]  m_axis_tuser
);

	localparam int unsigned CntW = $clog2(CAPACITY + 1);

	logic [CntW-1:0]            count_q;
	logic                       accept;
	logic                       is_full;
	logic                       is_none;
	speq_pkg::cmd_t             cmd;
	speq_pkg::edge_t            in_edge;
	speq_pkg::cell_ctrl_t       ctrl;
	speq_pkg::edge_t            cell_edge [CAPACITY];
	logic [CAPACITY-1:0]        cell_less;
	logic [CAPACITY-1:0]        cell_valid;
	logic [CntW-1:0]            count_next;
	logic [CntW+speq_pkg::CountW-1:0] count_wide;

	speq_pkg::status_t          status_d;
	speq_pkg::edge_t            out_edge_d;

	logic                       out_valid_q;
	speq_pkg::status_t          status_q;
	speq_pkg::edge_t            out_edge_q;
	logic [speq_pkg::CountW-1:0] entry_count_q;
	logic                       is_empty_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign cmd     = speq_pkg::cmd_t'(s_axis_tuser);
	assign in_edge = s_axis_tdata[35:0];
	assign is_full = (count_q == CntW'(CAPACITY));
	assign is_none = (count_q == '0);

	always_comb begin
		ctrl.ins_en   = accept && (cmd == speq_pkg::CMD_INSERT) && !is_full;
		ctrl.rem_en   = accept && (cmd == speq_pkg::CMD_REMOVE) && !is_none;
		ctrl.new_edge = in_edge;
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			assign cell_valid[gi] = (CntW'(gi) < count_q);
			speq_cell u_cell (
				.clk        (clk),
				.slot_valid (cell_valid[gi]),
				.ctrl       (ctrl),
				.left_less  ((gi == 0) ? 1'b1 : cell_less[(gi == 0) ? 0 : gi - 1]),
				.left_edge  (cell_edge[(gi == 0) ? 0 : gi - 1]),
				.right_edge (cell_edge[(gi == CAPACITY - 1) ? gi : gi + 1]),
				.less       (cell_less[gi]),
				.edge_q     (cell_edge[gi])
			);
		end
	endgenerate

	always_comb begin
		count_next = count_q;
		status_d   = speq_pkg::ST_INSERTED;
		out_edge_d = '0;
		if (cmd == speq_pkg::CMD_INSERT) begin
			if (is_full) begin
				status_d = speq_pkg::ST_DROPPED;
			end else begin
				count_next = count_q + CntW'(1);
			end
		end else begin
			if (is_none) begin
				status_d = speq_pkg::ST_EMPTY;
			end else begin
				status_d   = speq_pkg::ST_REMOVED;
				out_edge_d = cell_edge[0];
				count_next = count_q - CntW'(1);
			end
		end
	end

	// entry count is taken modulo its field width
	assign count_wide = {{speq_pkg::CountW{1'b0}}, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_d;
			out_edge_q    <= out_edge_d;
			entry_count_q <= count_wide[speq_pkg::CountW-1:0];
			is_empty_q    <= (count_next == '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {4'b0, is_empty_q, entry_count_q, out_edge_q};

endmodule
